[hdl/lrf_pkg.sv]
// Shared types and constants for the least-squares line fit block.
// Used by lrf_accum, lrf_muldiv, lrf_fit and linear_regression_fit_unit.
// No dependencies.
package lrf_pkg;

	// Sample limit; samples beyond it are dropped from the sums
	localparam int MAX_SAMPLES = 4096;
	localparam int LOG_MAX     = $clog2(MAX_SAMPLES);

	// Accumulator widths
	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
	localparam int SX_W    = 16 + LOG_MAX + 1;
	localparam int SXX_W   = 31 + LOG_MAX;
	localparam int SXY_W   = 32 + LOG_MAX;

	// Shared multiply/divide unit widths
	localparam int Q_W     = 32;                     // Q16.16 result word
	localparam int XMAG_W  = SX_W - 1;               // multiplier operand, steps per multiply
	localparam int PROD_W  = Q_W + XMAG_W;           // signed products and differences
	localparam int REM_W   = CNT_W + SXX_W + 1;      // multiplicand / divisor / remainder
	localparam int LO_W    = PROD_W - 8;             // low shift word
	localparam int STEP_W  = $clog2(LO_W + 1);

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DEGEN = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	typedef enum logic {
		MD_MUL,
		MD_DIV
	} md_op_t;

	// Command to the shared unit
	typedef struct packed {
		logic              go;
		md_op_t            op;
		logic [REM_W-1:0]  a;       // multiplicand or divisor
		logic [REM_W-1:0]  rem0;    // initial remainder (divide)
		logic [LO_W-1:0]   lo;      // multiplier bits or dividend bits
		logic [STEP_W-1:0] steps;
	} md_cmd_t;

	// Response from the shared unit
	typedef struct packed {
		logic              done;
		logic [LO_W-1:0]   quo;
		logic [PROD_W-1:0] prod;
	} md_rsp_t;

	// Running sums
	typedef struct packed {
		logic [CNT_W-1:0]        cnt;
		logic signed [SX_W-1:0]  sx;
		logic signed [SX_W-1:0]  sy;
		logic [SXX_W-1:0]        sxx;
		logic signed [SXY_W-1:0] sxy;
	} sums_t;

endpackage

[hdl/lrf_accum.sv]
// Sample accumulator: count and sums of x, y, x*x and x*y.
// Two-stage: products registered, then added into the sums.
// Depends on lrf_pkg.
module lrf_accum import lrf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               smp_vld,
	input  logic signed [15:0] x_in,
	input  logic signed [15:0] y_in,
	input  logic               clr,
	output sums_t              sums
);

	logic signed [31:0] xx_w;
	logic signed [31:0] xy_w;

	logic               vld_s1;
	logic [30:0]        xx_s1;
	logic signed [31:0] xy_s1;
	logic signed [15:0] x_s1;
	logic signed [15:0] y_s1;

	logic [CNT_W-1:0]        cnt_q;
	logic signed [SX_W-1:0]  sx_q;
	logic signed [SX_W-1:0]  sy_q;
	logic [SXX_W-1:0]        sxx_q;
	logic signed [SXY_W-1:0] sxy_q;

	assign xx_w = x_in * x_in;
	assign xy_w = x_in * y_in;

	// stage 1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			xx_s1  <= '0;
			xy_s1  <= '0;
			x_s1   <= '0;
			y_s1   <= '0;
		end else begin
			vld_s1 <= smp_vld;
			if (smp_vld) begin
				xx_s1 <= xx_w[30:0];
				xy_s1 <= xy_w;
				x_s1  <= x_in;
				y_s1  <= y_in;
			end
		end
	end

	// stage 2: sums; samples past the limit are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			sxy_q <= '0;
		end else if (clr) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			sxy_q <= '0;
		end else if (vld_s1 && (cnt_q < CNT_W'(MAX_SAMPLES))) begin
			cnt_q <= cnt_q + CNT_W'(1);
			sx_q  <= sx_q + SX_W'(x_s1);
			sy_q  <= sy_q + SX_W'(y_s1);
			sxx_q <= sxx_q + SXX_W'(xx_s1);
			sxy_q <= sxy_q + SXY_W'(xy_s1);
		end
	end

	assign sums.cnt = cnt_q;
	assign sums.sx  = sx_q;
	assign sums.sy  = sy_q;
	assign sums.sxx = sxx_q;
	assign sums.sxy = sxy_q;

endmodule

[hdl/lrf_muldiv.sv]
// Shared iterative unit: shift-add multiply and restoring divide on one adder.
// One bit per cycle; unsigned magnitudes only.
// Depends on lrf_pkg.
module lrf_muldiv import lrf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  md_cmd_t cmd,
	output md_rsp_t rsp
);

	md_op_t            op_q;
	logic [REM_W-1:0]  a_q;
	logic [REM_W-1:0]  acc_q;
	logic [LO_W-1:0]   lo_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic              is_div;
	logic [REM_W-1:0]  r_sh;
	logic [REM_W-1:0]  opx;
	logic [REM_W-1:0]  opy;
	logic [REM_W:0]    sum;
	logic [REM_W-1:0]  acc_n;
	logic [LO_W-1:0]   lo_n;

	assign is_div = (op_q == MD_DIV);
	assign r_sh   = {acc_q[REM_W-2:0], lo_q[LO_W-1]};

	// the one adder: acc + addend, or remainder - divisor
	assign opx = is_div ? r_sh : acc_q;
	assign opy = is_div ? ~a_q : (lo_q[0] ? a_q : '0);
	assign sum = {1'b0, opx} + {1'b0, opy} + (REM_W+1)'(is_div);

	always_comb begin
		if (is_div) begin
			// carry out means no borrow: quotient bit is one
			acc_n = sum[REM_W] ? sum[REM_W-1:0] : r_sh;
			lo_n  = {lo_q[LO_W-2:0], sum[REM_W]};
		end else begin
			acc_n = sum[REM_W:1];
			lo_n  = {sum[0], lo_q[LO_W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= MD_MUL;
			a_q    <= '0;
			acc_q  <= '0;
			lo_q   <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			// done pulses on the cycle after the last step
			done_q <= !cmd.go && busy_q && (cnt_q == STEP_W'(1));
			if (cmd.go) begin
				op_q   <= cmd.op;
				a_q    <= cmd.a;
				acc_q  <= (cmd.op == MD_DIV) ? cmd.rem0 : '0;
				lo_q   <= cmd.lo;
				cnt_q  <= cmd.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= acc_n;
				lo_q  <= lo_n;
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = lo_q;
	assign rsp.prod = {acc_q[PROD_W-XMAG_W-1:0], lo_q[LO_W-1 -: XMAG_W]};

endmodule

[hdl/lrf_fit.sv]
// Fit sequencer: forms the slope and intercept from the sums with the
// shared multiply/divide unit. Depends on lrf_pkg; drives lrf_muldiv.
module lrf_fit import lrf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  sums_t     sums,
	input  md_rsp_t   rsp,
	output md_cmd_t   cmd,
	output logic      done,
	output logic signed [Q_W-1:0] slope_o,
	output logic signed [Q_W-1:0] icpt_o,
	output logic [1:0] status_o
);

	typedef enum logic [3:0] {
		F_IDLE,
		F_P1,
		F_P2,
		F_DEN,
		F_P3,
		F_P4,
		F_NUM,
		F_MAG,
		F_CHK,
		F_DIV1,
		F_P5,
		F_INUM,
		F_DIV2,
		F_DONE
	} fstate_t;

	fstate_t                  state_q;
	logic                     issued_q;
	logic                     sat_q;
	logic signed [PROD_W-1:0] p1_q;
	logic signed [PROD_W-1:0] p2_q;
	logic [REM_W-1:0]         den_q;
	logic [REM_W-1:0]         num_mag_q;
	logic                     num_neg_q;
	logic signed [Q_W-1:0]    slope_q;
	logic signed [Q_W-1:0]    icpt_q;
	logic [1:0]               status_q;

	logic                     sx_neg, sy_neg, sxy_neg, slope_neg, inum_neg;
	logic [SX_W-1:0]          sx_abs, sy_abs;
	logic [SXY_W-1:0]         sxy_abs;
	logic [Q_W-1:0]           slope_abs;
	logic [PROD_W-1:0]        p1_abs, inum_abs;
	logic                     prod_neg;
	logic signed [PROD_W-1:0] prod_s;
	logic signed [PROD_W-1:0] pdiff;
	logic                     op_state;
	logic [Q_W:0]             clp;

	// Truncated magnitude with sign to Q16.16, saturating; top bit flags saturation
	function automatic logic [Q_W:0] clamp_q16(input logic neg, input logic [LO_W-1:0] mag);
		logic [Q_W:0] r;
		if (neg) begin
			if (mag > LO_W'(33'h0_8000_0000)) r = {1'b1, 32'h8000_0000};
			else                               r = {1'b0, ~mag[Q_W-1:0] + 32'd1};
		end else begin
			if (mag > LO_W'(33'h0_7fff_ffff)) r = {1'b1, 32'h7fff_ffff};
			else                               r = {1'b0, mag[Q_W-1:0]};
		end
		return r;
	endfunction

	// magnitudes and signs of the operands
	assign sx_neg    = sums.sx[SX_W-1];
	assign sy_neg    = sums.sy[SX_W-1];
	assign sxy_neg   = sums.sxy[SXY_W-1];
	assign slope_neg = slope_q[Q_W-1];
	assign inum_neg  = p2_q[PROD_W-1];
	assign sx_abs    = sx_neg ? (~sums.sx + SX_W'(1)) : sums.sx;
	assign sy_abs    = sy_neg ? (~sums.sy + SX_W'(1)) : sums.sy;
	assign sxy_abs   = sxy_neg ? (~sums.sxy + SXY_W'(1)) : sums.sxy;
	assign slope_abs = slope_neg ? (~slope_q + Q_W'(1)) : slope_q;
	assign p1_abs    = p1_q[PROD_W-1] ? (~p1_q + PROD_W'(1)) : p1_q;
	assign inum_abs  = inum_neg ? (~p2_q + PROD_W'(1)) : p2_q;

	assign pdiff = p1_q - p2_q;

	// sign of the product in flight
	always_comb begin
		case (state_q)
			F_P3:    prod_neg = sxy_neg;
			F_P4:    prod_neg = sy_neg ^ sx_neg;
			F_P5:    prod_neg = slope_neg ^ sx_neg;
			default: prod_neg = 1'b0;
		endcase
	end
	assign prod_s = prod_neg ? (~rsp.prod + PROD_W'(1)) : rsp.prod;

	assign clp = (state_q == F_DIV1) ? clamp_q16(num_neg_q, LO_W'(rsp.quo[Q_W-1:0]))
	                                 : clamp_q16(inum_neg, rsp.quo);

	assign op_state = (state_q == F_P1) || (state_q == F_P2) || (state_q == F_P3) ||
	                  (state_q == F_P4) || (state_q == F_P5) ||
	                  (state_q == F_DIV1) || (state_q == F_DIV2);

	// command to the shared unit, issued once on entry to each operation
	always_comb begin
		cmd       = '0;
		cmd.go    = op_state && !issued_q;
		cmd.op    = MD_MUL;
		cmd.steps = STEP_W'(XMAG_W);
		case (state_q)
			F_P1: begin
				cmd.a  = REM_W'(sums.sxx);
				cmd.lo = LO_W'(sums.cnt);
			end
			F_P2: begin
				cmd.a  = REM_W'(sx_abs[XMAG_W-1:0]);
				cmd.lo = LO_W'(sx_abs[XMAG_W-1:0]);
			end
			F_P3: begin
				cmd.a  = REM_W'(sxy_abs);
				cmd.lo = LO_W'(sums.cnt);
			end
			F_P4: begin
				cmd.a  = REM_W'(sy_abs[XMAG_W-1:0]);
				cmd.lo = LO_W'(sx_abs[XMAG_W-1:0]);
			end
			F_P5: begin
				cmd.a  = REM_W'(slope_abs);
				cmd.lo = LO_W'(sx_abs[XMAG_W-1:0]);
			end
			F_DIV1: begin
				// num * 2^16 / den: upper bits preload the remainder
				cmd.op    = MD_DIV;
				cmd.a     = den_q;
				cmd.rem0  = REM_W'(num_mag_q[REM_W-1:16]);
				cmd.lo    = {num_mag_q[15:0], {(LO_W-16){1'b0}}};
				cmd.steps = STEP_W'(Q_W);
			end
			F_DIV2: begin
				// divide by 256*n as (|num| >> 8) / n
				cmd.op    = MD_DIV;
				cmd.a     = REM_W'(sums.cnt);
				cmd.lo    = inum_abs[PROD_W-1:8];
				cmd.steps = STEP_W'(LO_W);
			end
			default: begin
				cmd.op = MD_MUL;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			issued_q  <= 1'b0;
			sat_q     <= 1'b0;
			p1_q      <= '0;
			p2_q      <= '0;
			den_q     <= '0;
			num_mag_q <= '0;
			num_neg_q <= 1'b0;
			slope_q   <= '0;
			icpt_q    <= '0;
			status_q  <= ST_OK;
		end else begin
			if (cmd.go) issued_q <= 1'b1;
			else if (rsp.done) issued_q <= 1'b0;

			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						sat_q   <= 1'b0;
						state_q <= F_P1;
					end
				end
				F_P1: begin
					if (rsp.done) begin
						p1_q    <= prod_s;
						state_q <= F_P2;
					end
				end
				F_P2: begin
					if (rsp.done) begin
						p2_q    <= prod_s;
						state_q <= F_DEN;
					end
				end
				F_DEN: begin
					// zero denominator: no fit
					if (pdiff[PROD_W-1] || (pdiff == '0)) begin
						slope_q  <= '0;
						icpt_q   <= '0;
						status_q <= ST_DEGEN;
						state_q  <= F_DONE;
					end else begin
						den_q   <= pdiff[REM_W-1:0];
						state_q <= F_P3;
					end
				end
				F_P3: begin
					if (rsp.done) begin
						p1_q    <= prod_s;
						state_q <= F_P4;
					end
				end
				F_P4: begin
					if (rsp.done) begin
						p2_q    <= prod_s;
						state_q <= F_NUM;
					end
				end
				F_NUM: begin
					p1_q    <= pdiff;
					state_q <= F_MAG;
				end
				F_MAG: begin
					num_neg_q <= p1_q[PROD_W-1];
					num_mag_q <= p1_abs[REM_W-1:0];
					state_q   <= F_CHK;
				end
				F_CHK: begin
					// integer part of the slope past 16 bits: clamp without dividing
					if (REM_W'(num_mag_q[REM_W-1:16]) >= den_q) begin
						sat_q   <= 1'b1;
						slope_q <= num_neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
						state_q <= F_P5;
					end else begin
						state_q <= F_DIV1;
					end
				end
				F_DIV1: begin
					if (rsp.done) begin
						slope_q <= clp[Q_W-1:0];
						sat_q   <= sat_q | clp[Q_W];
						state_q <= F_P5;
					end
				end
				F_P5: begin
					if (rsp.done) begin
						p1_q    <= prod_s;
						state_q <= F_INUM;
					end
				end
				F_INUM: begin
					// Sy in Q16 position minus slope*Sx
					p2_q    <= (PROD_W'(sums.sy) <<< 16) - p1_q;
					state_q <= F_DIV2;
				end
				F_DIV2: begin
					if (rsp.done) begin
						icpt_q   <= clp[Q_W-1:0];
						status_q <= (sat_q | clp[Q_W]) ? ST_SAT : ST_OK;
						state_q  <= F_DONE;
					end
				end
				F_DONE: begin
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign done     = (state_q == F_DONE);
	assign slope_o  = slope_q;
	assign icpt_o   = icpt_q;
	assign status_o = status_q;

endmodule

[hdl/linear_regression_fit_unit.sv]
// Top level of the least-squares line fit block.
// Depends on lrf_pkg, lrf_accum, lrf_muldiv and lrf_fit.
//
// Takes (x, y) samples in signed Q8.8 and keeps the count and the sums of
// x, y, x*x and x*y (at most 4096 samples; later ones are dropped). A word
// with last set closes the set: the block fits y = intercept + slope * x and
// returns one result word with slope and intercept in signed Q16.16 (each
// division truncated toward zero, the slope truncated before it feeds the
// intercept), status 0 for ok, 1 when all x are equal or fewer than two
// samples were kept (outputs zero), 2 when a result was clamped. The sums
// then clear for the next set. A sample without last is accepted in T_IDLE;
// its products are registered, then added into the sums while the state
// is in T_ACC, and the input is ready again in T_IDLE. A closing sample
// adds the fit, set by the single shared add/subtract unit that works one
// bit per cycle: five multiplies of 28 steps, a 32-step slope division and
// a 52-step intercept division; a degenerate set ends after two multiplies.
// The result sits in an output register until taken; the next set's first
// sample can be accepted while it waits.
module linear_regression_fit_unit import lrf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] x_sample,
	input  logic signed [15:0] y_sample,
	input  logic               last,
	input  logic               in_valid,
	output logic               in_ready,
	output logic signed [31:0] slope,
	output logic signed [31:0] intercept,
	output logic [1:0]         status,
	output logic               out_valid,
	input  logic               out_ready
);

	typedef enum logic [1:0] {
		T_IDLE,
		T_ACC,
		T_FIT,
		T_PUT
	} tstate_t;

	tstate_t            state_q;
	logic               last_q;
	logic               out_vld_q;
	logic signed [31:0] slope_q;
	logic signed [31:0] icpt_q;
	logic [1:0]         status_q;

	logic               accept;
	logic               load;
	logic               fit_start;
	logic               fit_done;
	sums_t              sums;
	md_cmd_t            md_cmd;
	md_rsp_t            md_rsp;
	logic signed [Q_W-1:0] fit_slope;
	logic signed [Q_W-1:0] fit_icpt;
	logic [1:0]         fit_status;

	assign in_ready  = (state_q == T_IDLE);
	assign accept    = in_valid && in_ready;
	assign fit_start = (state_q == T_ACC) && last_q;
	assign load      = (state_q == T_PUT) && (!out_vld_q || out_ready);

	lrf_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.smp_vld (accept),
		.x_in    (x_sample),
		.y_in    (y_sample),
		.clr     (load),
		.sums    (sums)
	);

	lrf_fit u_fit (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (fit_start),
		.sums     (sums),
		.rsp      (md_rsp),
		.cmd      (md_cmd),
		.done     (fit_done),
		.slope_o  (fit_slope),
		.icpt_o   (fit_icpt),
		.status_o (fit_status)
	);

	lrf_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (md_cmd),
		.rsp    (md_rsp)
	);

	// control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			last_q    <= 1'b0;
			out_vld_q <= 1'b0;
			slope_q   <= '0;
			icpt_q    <= '0;
			status_q  <= ST_OK;
		end else begin
			if (load) begin
				out_vld_q <= 1'b1;
				slope_q   <= fit_slope;
				icpt_q    <= fit_icpt;
				status_q  <= fit_status;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						last_q  <= last;
						state_q <= T_ACC;
					end
				end
				T_ACC: begin
					state_q <= last_q ? T_FIT : T_IDLE;
				end
				T_FIT: begin
					if (fit_done) state_q <= T_PUT;
				end
				T_PUT: begin
					if (load) state_q <= T_IDLE;
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_vld_q;
	assign slope     = slope_q;
	assign intercept = icpt_q;
	assign status    = status_q;

endmodule
